// File: hdl/pcba_pkg.sv
// Shared types, codes and helpers for the page color bin allocator.
`default_nettype none
package pcba_pkg;

	localparam int ACT_W       = 3;
	localparam int PAGE_W      = 20;
	localparam int ADDR_W      = 32;
	localparam int STAT_W      = 2;
	localparam int BIN_OUT_W   = 8;
	localparam int CFG_W       = 4;
	localparam int SPACE_SHIFT = 3;

	localparam logic [ACT_W-1:0] ACT_ADD_FREE  = 3'd0;
	localparam logic [ACT_W-1:0] ACT_ADD_CACHE = 3'd1;
	localparam logic [ACT_W-1:0] ACT_REM_FREE  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_REM_CACHE = 3'd3;
	localparam logic [ACT_W-1:0] ACT_GET_FREE  = 3'd4;
	localparam logic [ACT_W-1:0] ACT_GET_CACHE = 3'd5;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NONE  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [PAGE_W-1:0] page_number;
		logic [ADDR_W-1:0] space_handle;
		logic [ADDR_W-1:0] virtual_address;
		logic              match_color;
	} in_word_t;

	typedef struct packed {
		logic [STAT_W-1:0]    status;
		logic [BIN_OUT_W-1:0] bin_index;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_UPDATE,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		BIN_HOLD,
		BIN_PAGE,
		BIN_TARGET,
		BIN_FOUND
	} bin_sel_t;

	typedef enum logic [1:0] {
		RES_ZERO,
		RES_MISS,
		RES_UPD
	} res_sel_t;

	typedef struct packed {
		logic     load_item;
		bin_sel_t bin_sel;
		logic     rd_en;
		logic     scan_start;
		logic     scan_step;
		logic     wr_en;
		logic     res_set;
		res_sel_t res_sel;
		logic     load_out;
	} cmd_t;

	typedef struct packed {
		logic [ACT_W-1:0] act;
		logic             tgt_ne;
		logic             match;
		logic             hit;
		logic             last;
	} sts_t;

	function automatic logic act_is_add(input logic [ACT_W-1:0] act);
		return (act == ACT_ADD_FREE) || (act == ACT_ADD_CACHE);
	endfunction

	function automatic logic act_is_rem(input logic [ACT_W-1:0] act);
		return (act == ACT_REM_FREE) || (act == ACT_REM_CACHE);
	endfunction

	function automatic logic act_is_get(input logic [ACT_W-1:0] act);
		return (act == ACT_GET_FREE) || (act == ACT_GET_CACHE);
	endfunction

endpackage
`default_nettype wire

// File: hdl/pcba_ctrl.sv
// Sequencing state machine: handshakes, probe order and datapath commands.
`default_nettype none
module pcba_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  wire logic          out_stall,
	input  wire pcba_pkg::sts_t sts,
	output pcba_pkg::cmd_t     cmd
);
	import pcba_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (act_is_add(sts.act) || act_is_rem(sts.act)) begin
					cmd.bin_sel = BIN_PAGE;
					cmd.rd_en   = 1'b1;
					state_d     = ST_UPDATE;
				end else if (act_is_get(sts.act)) begin
					if (sts.tgt_ne) begin
						cmd.bin_sel = BIN_TARGET;
						cmd.rd_en   = 1'b1;
						state_d     = ST_UPDATE;
					end else if (sts.match) begin
						cmd.res_set = 1'b1;
						cmd.res_sel = RES_MISS;
						state_d     = ST_FINISH;
					end else begin
						cmd.scan_start = 1'b1;
						state_d        = ST_SCAN;
					end
				end else begin
					cmd.res_set = 1'b1;
					cmd.res_sel = RES_ZERO;
					state_d     = ST_FINISH;
				end
			end
			ST_SCAN: begin
				if (sts.hit) begin
					cmd.bin_sel = BIN_FOUND;
					cmd.rd_en   = 1'b1;
					state_d     = ST_UPDATE;
				end else if (sts.last) begin
					cmd.res_set = 1'b1;
					cmd.res_sel = RES_MISS;
					state_d     = ST_FINISH;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			ST_UPDATE: begin
				cmd.wr_en   = 1'b1;
				cmd.res_set = 1'b1;
				cmd.res_sel = RES_UPD;
				state_d     = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// File: hdl/pcba_dp.sv
// Datapath: color register, nonempty bitmaps, count memory, scan and result.
`default_nettype none
module pcba_dp #(
	parameter int MAX_COLORS  = 256,
	parameter int COUNT_WIDTH = 16,
	parameter int SKIP_STEP   = 19,
	parameter int PAGE_SHIFT  = 12
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [pcba_pkg::CFG_W-1:0]      cfg_data,
	input  wire pcba_pkg::in_word_t              in_word,
	input  wire pcba_pkg::cmd_t                  cmd,
	output pcba_pkg::sts_t                       sts,
	output pcba_pkg::out_word_t                  out_word
);
	import pcba_pkg::*;

	localparam int BW     = $clog2(MAX_COLORS);
	localparam int CW     = (MAX_COLORS < 32) ? MAX_COLORS : 32;
	localparam int JW     = $clog2(CW);
	localparam int NCH    = MAX_COLORS / CW;
	localparam int CHW    = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int CNT_W  = $clog2(NCH + 1);
	localparam int DEPTH  = 2 * MAX_COLORS;

	logic [CFG_W-1:0]       cfg_l2_q;
	logic [BW-1:0]          mask;
	logic [ACT_W-1:0]       act_q;
	logic                   list_q;
	logic                   match_q;
	logic [BW-1:0]          page_bin_q;
	logic [BW-1:0]          target_q;
	logic [BW-1:0]          skip_q;
	logic [BW-1:0]          target_d;
	logic [BW-1:0]          bin_q;
	logic [BW-1:0]          bin_d;
	logic [CHW-1:0]         chunk_q;
	logic [CNT_W-1:0]       pass_q;
	logic [1:0][MAX_COLORS-1:0] ne_q;
	logic [COUNT_WIDTH-1:0] cnt_mem [DEPTH];
	logic [COUNT_WIDTH-1:0] rd_q;
	logic [STAT_W-1:0]      res_status_q;
	logic [BIN_OUT_W-1:0]   res_bin_q;
	out_word_t              out_q;

	logic [CW-1:0]          chunk_bits;
	logic [CW-1:0]          elig;
	logic [BW-1:0]          chunk_base;
	logic [BW-1:0]          idx;
	logic [JW-1:0]          found_j;
	logic [BW-1:0]          found;
	logic                   cur_ne;
	logic [COUNT_WIDTH-1:0] cur;
	logic [COUNT_WIDTH-1:0] nxt;
	logic                   do_write;
	logic                   is_add;

	// Bin mask: log2 values past the bin width saturate to all ones.
	always_comb begin
		for (int i = 0; i < BW; i++)
			mask[i] = (cfg_l2_q > CFG_W'(i));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cfg_l2_q <= '0;
		else if (cfg_we)
			cfg_l2_q <= cfg_data;
	end

	assign target_d = (in_word.virtual_address[PAGE_SHIFT +: BW]
		+ in_word.space_handle[SPACE_SHIFT +: BW]) & mask;

	// Hold the item's decoded fields.
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			act_q      <= in_word.action;
			list_q     <= in_word.action[0];
			match_q    <= in_word.match_color;
			page_bin_q <= in_word.page_number[BW-1:0] & mask;
			target_q   <= target_d;
			skip_q     <= (target_d + BW'(SKIP_STEP)) & mask;
		end
	end

	// Scan chunk: eligible bins lie inside the mask and, on the first pass,
	// at or above the skip bin.
	assign chunk_bits = ne_q[list_q][chunk_q * CW +: CW];
	assign chunk_base = BW'(chunk_q) << JW;

	always_comb begin
		elig    = '0;
		found_j = '0;
		idx     = '0;
		for (int j = 0; j < CW; j++) begin
			idx     = chunk_base | BW'(j);
			elig[j] = chunk_bits[j] && ((idx & ~mask) == '0)
				&& ((pass_q != '0) || (JW'(j) >= skip_q[JW-1:0]));
		end
		for (int j = CW - 1; j >= 0; j--) begin
			if (elig[j])
				found_j = JW'(j);
		end
	end

	assign found = chunk_base | BW'(found_j);

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			chunk_q <= CHW'(skip_q >> JW);
			pass_q  <= '0;
		end else if (cmd.scan_step) begin
			chunk_q <= (chunk_q == CHW'(NCH - 1)) ? '0 : chunk_q + 1'b1;
			pass_q  <= pass_q + 1'b1;
		end
	end

	always_comb begin
		case (cmd.bin_sel)
			BIN_PAGE:   bin_d = page_bin_q;
			BIN_TARGET: bin_d = target_q;
			BIN_FOUND:  bin_d = found;
			default:    bin_d = bin_q;
		endcase
	end

	always_ff @(posedge clk) begin
		bin_q <= bin_d;
	end

	// Count update; a bin whose nonempty bit is clear counts as zero.
	assign is_add   = act_is_add(act_q);
	assign cur_ne   = ne_q[list_q][bin_q];
	assign cur      = cur_ne ? rd_q : '0;
	assign nxt      = is_add ? ((cur == '1) ? cur : COUNT_WIDTH'(cur + 1'b1))
		: COUNT_WIDTH'(cur - 1'b1);
	assign do_write = cmd.wr_en && (is_add || cur_ne);

	always_ff @(posedge clk) begin
		if (do_write)
			cnt_mem[{list_q, bin_q}] <= nxt;
		if (cmd.rd_en)
			rd_q <= cnt_mem[{list_q, bin_d}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ne_q <= '0;
		else if (do_write)
			ne_q[list_q][bin_q] <= (nxt != '0);
	end

	always_ff @(posedge clk) begin
		if (cmd.res_set) begin
			case (cmd.res_sel)
				RES_MISS: begin
					res_status_q <= STAT_NONE;
					res_bin_q    <= BIN_OUT_W'(target_q);
				end
				RES_UPD: begin
					res_status_q <= (!is_add && !cur_ne) ? STAT_EMPTY : STAT_OK;
					res_bin_q    <= BIN_OUT_W'(bin_q);
				end
				default: begin
					res_status_q <= STAT_OK;
					res_bin_q    <= '0;
				end
			endcase
		end
		if (cmd.load_out) begin
			out_q.status    <= res_status_q;
			out_q.bin_index <= res_bin_q;
		end
	end

	assign sts.act    = act_q;
	assign sts.tgt_ne = ne_q[list_q][target_q];
	assign sts.match  = match_q;
	assign sts.hit    = |elig;
	assign sts.last   = (pass_q == CNT_W'(NCH));
	assign out_word   = out_q;

endmodule
`default_nettype wire

// File: hdl/page_color_bin_allocator_top.sv
// Top level of the page color bin allocator: controller plus datapath.
// Flow: add, remove and a get served by its target bin decode the word, read the count,
// write it back as the result is set, then register the result word; no new word is taken
// before then. A get that misses its target without match_color scans the nonempty bitmap
// 32 bins a cycle (MAX_COLORS if fewer) from target + SKIP_STEP with wraparound.
// Reset: async, clears the nonempty bitmaps and the color register; no clearing pass.
`default_nettype none
module page_color_bin_allocator_top #(
	parameter int MAX_COLORS  = 256,
	parameter int COUNT_WIDTH = 16,
	parameter int SKIP_STEP   = 19,
	parameter int PAGE_SHIFT  = 12
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// Color count register: log2 of the number of bins.
	input  wire logic                       cfg_we,
	input  wire logic [pcba_pkg::CFG_W-1:0] cfg_data,
	// Request words.
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire pcba_pkg::in_word_t         in_word,
	// Result words.
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output pcba_pkg::out_word_t             out_word
);
	import pcba_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequence each word: decode, optional bitmap scan, optional count update,
	// then hold the result until the output side takes it.
	pcba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Hold counts in one memory (free list in the lower half, cache list in
	// the upper half) with a per-bin nonempty bit that drives the search.
	pcba_dp #(
		.MAX_COLORS  (MAX_COLORS),
		.COUNT_WIDTH (COUNT_WIDTH),
		.SKIP_STEP   (SKIP_STEP),
		.PAGE_SHIFT  (PAGE_SHIFT)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.in_word  (in_word),
		.cmd      (cmd),
		.sts      (sts),
		.out_word (out_word)
	);

endmodule
`default_nettype wire

// File: bench/tb_page_color_bin_allocator_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the page color bin allocator: bin counts, masks and skip-then-step gets.
module tb_page_color_bin_allocator_top;
	import pcba_pkg::*;

	localparam int MAX_COLORS  = 256;
	localparam int COUNT_WIDTH = 16;
	localparam int SKIP_STEP   = 19;
	localparam int PAGE_SHIFT  = 12;
	localparam int BIN_W       = $clog2(MAX_COLORS);

	// Actions 6 and 7 are spare: no effect, answer OK with bin 0.
	localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
	localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

	localparam bit LIST_FREE  = 1'b0;
	localparam bit LIST_CACHE = 1'b1;

	localparam int STALL_LIMIT    = 4000;  // cycles with no word moving
	localparam int TAIL_CYCLES    = 16;    // covers the longest scan plus margin
	localparam int BURST_ADDS     = 16;    // adds piled onto one bin back to back
	localparam int PHASE_WORDS    = 60;
	localparam int RECENT_DEPTH   = 32;
	localparam int MAX_ERR_LINES  = 40;

	logic             clk      = 1'b0;
	logic             arst_n   = 1'b0;
	logic             cfg_we   = 1'b0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	in_word_t         in_word  = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	out_word_t        out_word;

	// Predictor state: one count per bin for each list, plus the color register.
	bit [COUNT_WIDTH-1:0] bin_counts [2][MAX_COLORS];
	bit [CFG_W-1:0]       model_log2 = '0;

	in_word_t  requests_to_send [$];  // front is the word on the bus
	out_word_t bin_answers_due [$];   // predicted answers, oldest first
	out_word_t due_word;

	// Recently added pages, reused to aim removes and exact-color gets at live bins.
	bit [PAGE_W-1:0] recent_pages [RECENT_DEPTH];
	int              recent_n = 0;

	int err_count   = 0;
	int words_sent  = 0;
	int words_seen  = 0;
	int gets_served = 0;
	int gets_none   = 0;
	int rem_empty   = 0;
	int adds_capped = 0;

	int in_gap      = 0;
	int in_calm     = 0;
	int stall_left  = 0;
	int out_calm    = 0;
	int idle_cycles = 0;
	bit no_idle     = 1'b0;

	page_color_bin_allocator_top #(
		.MAX_COLORS (MAX_COLORS),
		.COUNT_WIDTH(COUNT_WIDTH),
		.SKIP_STEP  (SKIP_STEP),
		.PAGE_SHIFT (PAGE_SHIFT)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word (out_word)
	);

	initial forever #1 clk = ~clk;

	task automatic flag_error(input string msg);
		if (err_count < MAX_ERR_LINES)
			$display("%0t mismatch: %s", $time, msg);
		err_count++;
	endtask

	// Gap length in cycles: mostly none or short, now and then long.
	function automatic int pick_gap(input int calm);
		int r;
		r = $urandom_range(99);
		if (no_idle || calm > 0)
			return 0;
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(12, 4);
		return $urandom_range(40, 20);
	endfunction

	// Apply one accepted request word to the bin counts and queue the answer it earns.
	task automatic apply_bin_request(input in_word_t w);
		out_word_t   ans;
		bit          lst;
		int          colors;
		int          i;
		logic [31:0] mask;
		logic [31:0] target;
		logic [31:0] bin;
		bit          done;
		// Cap the color count at the bin store size.
		colors = 1 << model_log2;
		if (colors > MAX_COLORS)
			colors = MAX_COLORS;
		mask = colors - 1;
		lst = (w.action == ACT_ADD_CACHE || w.action == ACT_REM_CACHE ||
			w.action == ACT_GET_CACHE) ? LIST_CACHE : LIST_FREE;
		ans.status    = STAT_OK;
		ans.bin_index = '0;
		case (w.action)
		ACT_ADD_FREE, ACT_ADD_CACHE: begin
			bin = w.page_number & mask;
			// Hold a full count at its maximum; the add still reports OK.
			if (bin_counts[lst][bin[BIN_W-1:0]] != {COUNT_WIDTH{1'b1}})
				bin_counts[lst][bin[BIN_W-1:0]]++;
			else
				adds_capped++;
			ans.bin_index = bin[BIN_OUT_W-1:0];
		end
		ACT_REM_FREE, ACT_REM_CACHE: begin
			bin = w.page_number & mask;
			if (bin_counts[lst][bin[BIN_W-1:0]] == 0) begin
				ans.status = STAT_EMPTY;
				rem_empty++;
			end else
				bin_counts[lst][bin[BIN_W-1:0]]--;
			ans.bin_index = bin[BIN_OUT_W-1:0];
		end
		ACT_GET_FREE, ACT_GET_CACHE: begin
			target = ((w.virtual_address >> PAGE_SHIFT) +
				(w.space_handle >> SPACE_SHIFT)) & mask;
			ans.status    = STAT_NONE;
			ans.bin_index = target[BIN_OUT_W-1:0];
			bin  = target;
			done = 1'b0;
			// Probe the target, then target + skip, then step by one: up to colors + 1 probes.
			for (i = 0; i <= colors && !done; i++) begin
				if (bin_counts[lst][bin[BIN_W-1:0]] != 0) begin
					bin_counts[lst][bin[BIN_W-1:0]]--;
					ans.status    = STAT_OK;
					ans.bin_index = bin[BIN_OUT_W-1:0];
					done = 1'b1;
				end else if (w.match_color)
					done = 1'b1;
				else
					bin = (bin + ((i == 0) ? SKIP_STEP : 1)) & mask;
			end
			if (ans.status == STAT_OK)
				gets_served++;
			else
				gets_none++;
		end
		default: ;
		endcase
		bin_answers_due.push_back(ans);
	endtask

	task automatic queue_request(input logic [ACT_W-1:0] act, input logic [PAGE_W-1:0] pg,
		input logic [ADDR_W-1:0] sh, input logic [ADDR_W-1:0] va, input logic m);
		in_word_t w;
		w.action          = act;
		w.page_number     = pg;
		w.space_handle    = sh;
		w.virtual_address = va;
		w.match_color     = m;
		requests_to_send.push_back(w);
	endtask

	// Random traffic: adds build up bins, removes mostly aim at live bins, exact-color gets often do.
	task automatic queue_random(input int n);
		int                r;
		int                k;
		logic [ACT_W-1:0]  act;
		logic [PAGE_W-1:0] pg;
		logic [PAGE_W-1:0] vpn;
		logic [ADDR_W-1:0] sh;
		logic [ADDR_W-1:0] va;
		logic              m;
		repeat (n) begin
			r  = $urandom_range(99);
			sh = $urandom;
			va = $urandom;
			pg = PAGE_W'($urandom);
			m  = 1'($urandom_range(1));
			k  = (recent_n > 0) ?
				$urandom_range(((recent_n < RECENT_DEPTH) ? recent_n : RECENT_DEPTH) - 1) : 0;
			if (r < 35) begin
				act = $urandom_range(1) ? ACT_ADD_CACHE : ACT_ADD_FREE;
				recent_pages[recent_n % RECENT_DEPTH] = pg;
				recent_n++;
			end else if (r < 57) begin
				act = $urandom_range(1) ? ACT_REM_CACHE : ACT_REM_FREE;
				if (recent_n > 0 && $urandom_range(99) < 70)
					pg = {pg[PAGE_W-1:8], recent_pages[k][7:0]};
			end else if (r < 94) begin
				act = $urandom_range(1) ? ACT_GET_CACHE : ACT_GET_FREE;
				// Steer the hash onto a recent page's bin so exact-color gets can hit.
				if (m && recent_n > 0 && $urandom_range(99) < 60) begin
					vpn = recent_pages[k] - sh[PAGE_W+SPACE_SHIFT-1:SPACE_SHIFT];
					va  = {vpn, va[PAGE_SHIFT-1:0]};
				end
			end else
				act = $urandom_range(1) ? ACT_SPARE_HI : ACT_SPARE_LO;
			queue_request(act, pg, sh, va, m);
		end
	endtask

	// Hold until every request is taken and every answer has come back.
	task automatic wait_idle();
		while (requests_to_send.size() != 0 || bin_answers_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_color_log2(input logic [CFG_W-1:0] l2);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= l2;
		@(posedge clk);
		cfg_we <= 1'b0;
		model_log2 = l2;
	endtask

	task automatic run_phase(input logic [CFG_W-1:0] l2, input int n);
		wait_idle();
		write_color_log2(l2);
		queue_random(n);
	endtask

	// Request driver: present the front word, hold it while stalled, drop it once taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				apply_bin_request(requests_to_send.pop_front());
				words_sent++;
				// Now and then run a stretch of words back to back.
				if (in_calm > 0)
					in_calm--;
				else if ($urandom_range(99) < 4)
					in_calm = $urandom_range(40, 10);
				in_gap = pick_gap(in_calm);
			end
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (requests_to_send.size() != 0) begin
					in_valid <= 1'b1;
					in_word  <= requests_to_send[0];
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// Result monitor: compare each taken word with the oldest answer, then pick the next stall.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				words_seen++;
				if (bin_answers_due.size() == 0)
					flag_error($sformatf("unexpected result word: status %0d bin %0d",
						out_word.status, out_word.bin_index));
				else begin
					due_word = bin_answers_due.pop_front();
					if (out_word.status !== due_word.status)
						flag_error($sformatf("word %0d status %0d, want %0d", words_seen,
							out_word.status, due_word.status));
					if (out_word.bin_index !== due_word.bin_index)
						flag_error($sformatf("word %0d bin %0d, want %0d", words_seen,
							out_word.bin_index, due_word.bin_index));
				end
			end
			if (out_calm > 0)
				out_calm--;
			else if ($urandom_range(99) < 3)
				out_calm = $urandom_range(60, 20);
			if (stall_left == 0)
				stall_left = pick_gap(out_calm);
			out_stall <= (stall_left > 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	// Watchdog: end the run if no word moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: %0d cycles with no word moving", idle_cycles);
				$display("tb_page_color_bin_allocator_top: errors");
				$finish;
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// One bin after reset: empty removes, empty gets, field extremes, spare actions.
		queue_request(ACT_REM_FREE, 20'hFFFFF, 32'h0, 32'h0, 1'b0);
		queue_request(ACT_REM_CACHE, 20'h0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1);
		queue_request(ACT_GET_FREE, 20'h0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0);
		queue_request(ACT_GET_CACHE, 20'hFFFFF, 32'h0, 32'h0, 1'b1);
		queue_request(ACT_ADD_FREE, 20'hFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1);
		queue_request(ACT_ADD_CACHE, 20'h0, 32'h0, 32'h0, 1'b0);
		queue_request(ACT_GET_FREE, 20'h0, 32'h0, 32'h0, 1'b1);
		queue_request(ACT_GET_CACHE, 20'hFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0);
		queue_request(ACT_SPARE_LO, 20'hFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1);
		queue_request(ACT_SPARE_HI, 20'h0, 32'h0, 32'h0, 1'b0);

		// 256 bins, target 200: skip lands on 219, then steps; wrap finds 205 last.
		wait_idle();
		write_color_log2(4'd8);
		queue_request(ACT_ADD_FREE, 20'd219, 32'h0, 32'h0, 1'b0);
		queue_request(ACT_ADD_FREE, 20'd220, 32'h0, 32'h0, 1'b0);
		queue_request(ACT_GET_FREE, 20'h0, 32'h0, 32'd200 << PAGE_SHIFT, 1'b1);
		queue_request(ACT_GET_FREE, 20'h0, 32'h0, 32'd200 << PAGE_SHIFT, 1'b0);
		queue_request(ACT_GET_FREE, 20'h0, 32'h0, 32'd200 << PAGE_SHIFT, 1'b0);
		queue_request(ACT_ADD_CACHE, 20'd205, 32'h0, 32'h0, 1'b0);
		queue_request(ACT_ADD_CACHE, 20'hFFFE1, 32'h0, 32'h0, 1'b0);
		queue_request(ACT_GET_CACHE, 20'h0, 32'h0, 32'd200 << PAGE_SHIFT, 1'b0);
		queue_request(ACT_GET_CACHE, 20'h0, 32'h0, 32'd200 << PAGE_SHIFT, 1'b0);
		queue_request(ACT_ADD_CACHE, 20'hFFFFF, 32'h0, 32'h0, 1'b0);
		queue_request(ACT_GET_CACHE, 20'h0, 32'h0, 32'd240 << PAGE_SHIFT, 1'b0);
		queue_request(ACT_REM_CACHE, 20'hFFFFF, 32'h0, 32'h0, 1'b0);
		queue_request(ACT_GET_FREE, 20'h0, 32'hFFFFFFF8, 32'h00001000, 1'b0);

		// Random traffic over a spread of color counts, capped values included.
		run_phase(4'd1, PHASE_WORDS);
		run_phase(4'd3, PHASE_WORDS);
		run_phase(4'd8, PHASE_WORDS);
		run_phase(4'd15, PHASE_WORDS);
		run_phase(4'd2, PHASE_WORDS);
		run_phase(4'd5, PHASE_WORDS);
		run_phase(4'd12, PHASE_WORDS);
		run_phase(4'd4, PHASE_WORDS);
		run_phase(4'd9, PHASE_WORDS);
		run_phase(4'd6, PHASE_WORDS);
		run_phase(4'd7, PHASE_WORDS);
		run_phase(4'd10, PHASE_WORDS);

		// Pile adds onto one free bin with no idling; an exact get must still hit.
		wait_idle();
		write_color_log2(4'd0);
		no_idle = 1'b1;
		repeat (BURST_ADDS)
			queue_request(ACT_ADD_FREE, PAGE_W'($urandom), $urandom, $urandom,
				1'($urandom_range(1)));
		queue_request(ACT_GET_FREE, PAGE_W'($urandom), $urandom, $urandom, 1'b1);
		queue_request(ACT_REM_FREE, PAGE_W'($urandom), $urandom, $urandom,
			1'($urandom_range(1)));
		queue_request(ACT_ADD_FREE, PAGE_W'($urandom), $urandom, $urandom,
			1'($urandom_range(1)));
		wait_idle();
		no_idle = 1'b0;

		// Drain: let any stray result word show up before the verdict.
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("ran %0d request words and %0d result words over 14 color settings",
			words_sent, words_seen);
		$display("gets served %0d, gets empty %0d, empty removes %0d, capped adds %0d",
			gets_served, gets_none, rem_empty, adds_capped);
		if (err_count == 0)
			$display("tb_page_color_bin_allocator_top: clean");
		else
			$display("tb_page_color_bin_allocator_top: errors");
		$finish;
	end

endmodule
